// File: design/rbub_pkg.sv
// Shared types and constants for the USB bulk IN ring buffer packetiser.
package rbub_pkg;

    localparam int RING_DEPTH     = 64;
    localparam int IDX_W          = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int LEN_W          = $clog2(RING_DEPTH + 1);
    localparam int BYTE_W         = 8;
    localparam int PKT_LEN_W      = 7;
    localparam int CMD_W          = 2;
    localparam int KIND_W         = 3;
    localparam int INTERVAL_W     = 8;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 16;
    localparam logic [INTERVAL_W-1:0] POLL_INTERVAL_RST = INTERVAL_W'(100);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT     = 2'd0,
        CMD_POLL    = 2'd1,
        CMD_IN_DONE = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT_OK   = 3'd0,
        KIND_PUT_FULL = 3'd1,
        KIND_BYTE     = 3'd2,
        KIND_ZLP      = 3'd3,
        KIND_NONE     = 3'd4,
        KIND_IDLE     = 3'd5
    } t_kind;

endpackage

// File: design/rbub_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module rbub_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ring_buffer_usb_bulk_packetizer.sv
// Top level: transmit byte ring and bulk IN packetiser with zero-length packet handling.
//
//  Channel   Direction  Handshake                    Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  one command word
//  m_axis    out        m_axis_tvalid/m_axis_tready  one result word
//  cfg       in         i_cfg_valid/o_cfg_ready      poll interval register
//
// Put, IN-complete and idle polls each give one result word.
// A poll that sends a packet of N bytes blocks the input until its last byte is loaded
// into the output register: the bytes stream from the ring RAM read port at one per cycle
// while the output is not stalled. A stalled output holds the RAM read pipeline in place.
// Reset is synchronous and immediate; the ring RAM is not cleared.
module ring_buffer_usb_bulk_packetizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] put_byte, [8] configured, [15:9] zero
    input  logic [rbub_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [rbub_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] packet_byte, [14:8] packet_length, [15] zero
    output logic [rbub_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [2:0] result_kind
    output logic [rbub_pkg::KIND_W-1:0]    m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rbub_pkg::INTERVAL_W-1:0] i_cfg_data
);

    import rbub_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    t_state                r_state;
    logic [IDX_W-1:0]      r_wr;
    logic [IDX_W-1:0]      r_rd;
    logic                  r_busy;
    logic                  r_full;
    logic [INTERVAL_W-1:0] r_frame;
    logic [INTERVAL_W-1:0] r_poll_interval;

    logic [IDX_W-1:0]      r_rd_ptr;
    logic [LEN_W-1:0]      r_issue_cnt;
    logic [LEN_W-1:0]      r_out_cnt;
    logic [PKT_LEN_W-1:0]  r_pkt_len;
    logic                  r_rd_vld;

    logic                  r_m_valid;
    t_kind                 r_kind;
    logic [BYTE_W-1:0]     r_byte;
    logic [PKT_LEN_W-1:0]  r_len;
    logic                  r_last;

    t_cmd                  cmd;
    logic [BYTE_W-1:0]     put_byte;
    logic                  configured;
    logic                  in_acc;
    logic [IDX_W-1:0]      wr_adv;
    logic                  due;
    logic                  ring_empty;
    logic [LEN_W-1:0]      pend_len;
    logic                  emit_go;
    logic                  consume;
    logic                  issue;
    logic                  out_load;
    logic                  ram_we;
    logic [BYTE_W-1:0]     ram_rdata;
    t_kind                 n_kind;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] nxt;
        nxt = {1'b0, idx} + 1'b1;
        if (nxt >= (IDX_W+1)'(RING_DEPTH)) begin
            nxt = '0;
        end
        return nxt[IDX_W-1:0];
    endfunction

    assign cmd        = t_cmd'(s_axis_tuser);
    assign put_byte   = s_axis_tdata[BYTE_W-1:0];
    assign configured = s_axis_tdata[BYTE_W];

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_m_valid || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign wr_adv     = advance(r_wr);
    assign due        = r_frame > r_poll_interval;
    assign ring_empty = (r_rd == r_wr) && !r_full;

    always_comb begin
        if (r_full) begin
            pend_len = LEN_W'(RING_DEPTH);
        end else if (r_wr >= r_rd) begin
            pend_len = LEN_W'(r_wr) - LEN_W'(r_rd);
        end else begin
            pend_len = LEN_W'(r_wr) + LEN_W'(RING_DEPTH) - LEN_W'(r_rd);
        end
    end

    assign emit_go = in_acc && (cmd == CMD_POLL) && configured && due && !r_busy
                     && !ring_empty;

    // The RAM read runs one word ahead of the output register.
    assign consume  = (r_state == ST_EMIT) && r_rd_vld && (!r_m_valid || m_axis_tready);
    assign issue    = (r_state == ST_EMIT) && (r_issue_cnt != '0) && (!r_rd_vld || consume);
    assign out_load = (in_acc && !emit_go) || consume;
    assign ram_we   = in_acc && (cmd == CMD_PUT) && !r_full;

    always_comb begin
        unique case (cmd)
            CMD_PUT:     n_kind = r_full ? KIND_PUT_FULL : KIND_PUT_OK;
            CMD_POLL:    n_kind = KIND_NONE;
            CMD_IN_DONE: n_kind = r_full ? KIND_ZLP : KIND_IDLE;
            default:     n_kind = KIND_NONE;
        endcase
    end

    rbub_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (BYTE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr),
        .i_wdata (put_byte),
        .i_re    (issue),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_wr            <= '0;
            r_rd            <= '0;
            r_busy          <= 1'b0;
            r_full          <= 1'b0;
            r_frame         <= '0;
            r_poll_interval <= POLL_INTERVAL_RST;
            r_rd_ptr        <= '0;
            r_issue_cnt     <= '0;
            r_out_cnt       <= '0;
            r_rd_vld        <= 1'b0;
            r_m_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_poll_interval <= i_cfg_data;
            end

            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (issue) begin
                r_rd_vld    <= 1'b1;
                r_rd_ptr    <= advance(r_rd_ptr);
                r_issue_cnt <= r_issue_cnt - 1'b1;
            end else if (consume) begin
                r_rd_vld <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (cmd == CMD_PUT && !r_full) begin
                            r_wr <= wr_adv;
                            if (wr_adv == r_rd) begin
                                r_full <= 1'b1;
                            end
                        end
                        if (cmd == CMD_POLL && configured) begin
                            r_frame <= due ? '0 : r_frame + 1'b1;
                        end
                        if (cmd == CMD_IN_DONE) begin
                            if (r_full) begin
                                r_full <= 1'b0;
                            end else begin
                                r_busy <= 1'b0;
                            end
                        end
                        if (emit_go) begin
                            // A full ring keeps both indices and stays full; either way all pending bytes go.
                            r_busy      <= 1'b1;
                            r_rd        <= r_wr;
                            r_rd_ptr    <= r_rd;
                            r_issue_cnt <= pend_len;
                            r_out_cnt   <= pend_len;
                            r_pkt_len   <= PKT_LEN_W'(pend_len);
                            r_state     <= ST_EMIT;
                        end else begin
                            r_kind    <= n_kind;
                            r_byte    <= '0;
                            r_len     <= '0;
                            r_last    <= 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (consume) begin
                        r_kind    <= KIND_BYTE;
                        r_byte    <= ram_rdata;
                        r_len     <= r_pkt_len;
                        r_last    <= (r_out_cnt == LEN_W'(1));
                        r_out_cnt <= r_out_cnt - 1'b1;
                        if (r_out_cnt == LEN_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(M_TDATA_W - BYTE_W - PKT_LEN_W)'(0), r_len, r_byte};
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;

endmodule

// File: design/rbub_checker.sv
// Port-level assertions for the packetiser, bound to the top level.
module rbub_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [rbub_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic [rbub_pkg::KIND_W-1:0]     m_axis_tuser,
    input logic                            m_axis_tlast
);

    import rbub_pkg::*;

    // Every result other than a packet byte is the only word of its command.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_BYTE) |-> m_axis_tlast)
        else $error("non-byte result without last");

    // Packet bytes carry a non-zero length; other results carry zero data.
    a_len_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == KIND_BYTE) ? (m_axis_tdata[14:8] != '0)
                                                       : (m_axis_tdata == '0)))
        else $error("packet length does not match result kind");

    // No command is taken while a packet is still being sent.
    a_block_mid_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_BYTE) && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted in the middle of a packet");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output word changed");

endmodule

bind ring_buffer_usb_bulk_packetizer rbub_checker u_rbub_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/sv/testbench.sv
// Self-checking testbench for the USB bulk IN ring buffer packetiser.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rbub_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned RANDOM_ITEMS = 320;

    typedef struct packed {
        t_kind                kind;
        logic [BYTE_W-1:0]    data;
        logic [PKT_LEN_W-1:0] len;
        logic                 last;
    } t_result;

    // Tracks the ring, the endpoint and the frame counter, and holds the result words still due.
    class bulk_in_tracker;
        logic [BYTE_W-1:0]     ring_bytes [RING_DEPTH];
        int unsigned           wr_ptr;
        int unsigned           rd_ptr;
        bit                    busy;
        bit                    full;
        logic [INTERVAL_W-1:0] frame_count;
        logic [INTERVAL_W-1:0] interval;
        t_result               pending [$];
        int unsigned           mismatches;
        int unsigned           words_checked;
        int unsigned           packets;
        int unsigned           zlps;
        int unsigned           rejected;

        function new();
            wr_ptr        = 0;
            rd_ptr        = 0;
            busy          = 0;
            full          = 0;
            frame_count   = '0;
            interval      = POLL_INTERVAL_RST;
            mismatches    = 0;
            words_checked = 0;
            packets       = 0;
            zlps          = 0;
            rejected      = 0;
        endfunction

        function int unsigned next_index(int unsigned idx);
            return (idx + 1 == RING_DEPTH) ? 0 : idx + 1;
        endfunction

        function bit has_data();
            return (wr_ptr != rd_ptr) || full;
        endfunction

        function void push(t_kind kind, logic [BYTE_W-1:0] data, int unsigned len, bit last);
            t_result r;
            r.kind = kind;
            r.data = data;
            r.len  = PKT_LEN_W'(len);
            r.last = last;
            pending.push_back(r);
        endfunction

        function void set_interval(logic [INTERVAL_W-1:0] value);
            interval = value;
        endfunction

        function void take_command(t_cmd cmd, logic [BYTE_W-1:0] data, bit cfgd);
            logic [INTERVAL_W-1:0] prev;
            bit                    due;
            int unsigned           len;
            int unsigned           idx;
            case (cmd)
                CMD_PUT: begin
                    if (full) begin
                        rejected++;
                        push(KIND_PUT_FULL, '0, 0, 1);
                    end else begin
                        ring_bytes[wr_ptr] = data;
                        wr_ptr = next_index(wr_ptr);
                        if (wr_ptr == rd_ptr) full = 1;
                        push(KIND_PUT_OK, '0, 0, 1);
                    end
                end
                CMD_POLL: begin
                    if (!cfgd) begin
                        push(KIND_NONE, '0, 0, 1);
                    end else begin
                        prev = frame_count;
                        frame_count = prev + 1'b1;
                        due = prev > interval;
                        if (!due || busy) begin
                            if (due) frame_count = '0;
                            push(KIND_NONE, '0, 0, 1);
                        end else begin
                            frame_count = '0;
                            if (!has_data()) begin
                                push(KIND_NONE, '0, 0, 1);
                            end else begin
                                // A full ring has equal indices and goes out whole.
                                busy = 1;
                                len = (rd_ptr == wr_ptr) ? RING_DEPTH
                                                         : (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
                                idx = rd_ptr;
                                for (int unsigned i = 0; i < len; i++) begin
                                    push(KIND_BYTE, ring_bytes[idx], len, i + 1 == len);
                                    idx = next_index(idx);
                                end
                                packets++;
                                rd_ptr = wr_ptr;
                            end
                        end
                    end
                end
                CMD_IN_DONE: begin
                    if (full) begin
                        full = 0;
                        zlps++;
                        push(KIND_ZLP, '0, 0, 1);
                    end else begin
                        busy = 0;
                        push(KIND_IDLE, '0, 0, 1);
                    end
                end
                default: push(KIND_NONE, '0, 0, 1);
            endcase
        endfunction

        function void match_result(t_kind kind, logic [BYTE_W-1:0] data,
                                   logic [PKT_LEN_W-1:0] len, logic last);
            t_result exp;
            if (pending.size() == 0) begin
                $error("unexpected result word: result_kind %0d, packet_byte %0h",
                       kind, data);
                mismatches++;
                return;
            end
            exp = pending.pop_front();
            words_checked++;
            if (kind !== exp.kind) begin
                $error("result_kind: expected %0d, got %0d", exp.kind, kind);
                mismatches++;
            end
            if (data !== exp.data) begin
                $error("packet_byte: expected %0h, got %0h", exp.data, data);
                mismatches++;
            end
            if (len !== exp.len) begin
                $error("packet_length: expected %0d, got %0d", exp.len, len);
                mismatches++;
            end
            if (last !== exp.last) begin
                $error("last: expected %0b, got %0b", exp.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [S_TDATA_W-1:0]    s_axis_tdata;
    logic [CMD_W-1:0]        s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [M_TDATA_W-1:0]    m_axis_tdata;
    logic [KIND_W-1:0]       m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [INTERVAL_W-1:0]   i_cfg_data;

    bulk_in_tracker tracker;
    int unsigned    cycle_count = 0;
    int unsigned    items_sent;
    bit             tx_gaps;
    bit             rx_gaps;

    ring_buffer_usb_bulk_packetizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Prediction and checking share one process, so a word taken in and a word sent out at
    // the same edge are always handled in that order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                tracker.set_interval(i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_command(t_cmd'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[8]);
            if (m_axis_tvalid && m_axis_tready)
                tracker.match_result(t_kind'(m_axis_tuser), m_axis_tdata[7:0],
                                     m_axis_tdata[14:8], m_axis_tlast);
        end
    end

    // Output back-pressure: random stalls while enabled.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_gaps && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = i_rst_n;
            end
        end
    end

    task automatic send_command(t_cmd cmd, logic [BYTE_W-1:0] data, logic cfgd);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {7'b0, cfgd, data};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_noise();
        send_command(t_cmd'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (tracker.pending.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_interval(logic [INTERVAL_W-1:0] value);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Put bytes into the ring, poll until a packet goes out, then complete the IN transfer.
    task automatic run_transfer(int unsigned n_puts, bit early_done);
        int unsigned guard;
        for (int unsigned i = 0; i < n_puts; i++) begin
            if ($urandom_range(0, 11) == 0) send_noise();
            send_command(CMD_PUT, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        if (tracker.full) begin
            repeat ($urandom_range(1, 2))
                send_command(CMD_PUT, BYTE_W'($urandom_range(0, 255)), 1'b1);
        end
        if (early_done) send_command(CMD_IN_DONE, BYTE_W'($urandom_range(0, 255)), 1'b1);
        guard = 0;
        while (!tracker.busy && tracker.has_data() && guard < 600) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            send_command(CMD_POLL, BYTE_W'($urandom_range(0, 255)),
                         $urandom_range(0, 7) != 0);
            guard++;
        end
        guard = 0;
        while ((tracker.busy || tracker.full) && guard < 6) begin
            if ($urandom_range(0, 3) == 0) send_command(CMD_POLL, '0, 1'b1);
            send_command(CMD_IN_DONE, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            guard++;
        end
    endtask

    task automatic random_transfers(int unsigned target);
        int unsigned pick;
        while (items_sent < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                run_transfer($urandom_range(1, 16), $urandom_range(0, 9) == 0);
            else if (pick < 18)
                run_transfer($urandom_range(17, RING_DEPTH - 1), $urandom_range(0, 9) == 0);
            else
                run_transfer(RING_DEPTH, $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        int unsigned base;
        tracker       = new();
        items_sent    = 0;
        tx_gaps       = 1;
        rx_gaps       = 1;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: idle completion, inert polls, unused command; then packets at interval 0.
        send_command(CMD_IN_DONE, 8'h00, 1'b0);
        send_command(CMD_POLL, 8'hFF, 1'b0);
        send_command(CMD_UNUSED, 8'hFF, 1'b1);
        send_command(CMD_POLL, 8'h00, 1'b1);
        send_command(CMD_POLL, 8'h00, 1'b1);
        send_command(CMD_PUT, 8'h00, 1'b0);
        write_interval(8'd0);
        send_command(CMD_PUT, 8'hFF, 1'b1);
        send_command(CMD_PUT, 8'hA5, 1'b0);
        send_command(CMD_POLL, 8'h00, 1'b1);
        send_command(CMD_PUT, 8'h5A, 1'b1);
        send_command(CMD_POLL, 8'h00, 1'b1);
        send_command(CMD_POLL, 8'h00, 1'b1);
        send_command(CMD_IN_DONE, 8'h00, 1'b1);
        send_command(CMD_POLL, 8'h00, 1'b1);
        send_command(CMD_POLL, 8'h00, 1'b1);
        send_command(CMD_IN_DONE, 8'hFF, 1'b0);

        // A full ring sent whole, then a full ring completed before it was ever sent.
        drain();
        base = items_sent;
        run_transfer(RING_DEPTH, 0);
        run_transfer(RING_DEPTH, 1);
        random_transfers(base + RANDOM_ITEMS / 2);

        // Largest interval: the frame counter never passes it, so no transfer is attempted.
        write_interval(8'd255);
        for (int unsigned i = 0; i < 40; i++) begin
            if (i % 16 == 3) send_command(CMD_PUT, BYTE_W'($urandom_range(0, 255)), 1'b1);
            send_command(CMD_POLL, BYTE_W'($urandom_range(0, 255)), 1'b1);
        end
        send_command(CMD_IN_DONE, 8'h00, 1'b1);

        write_interval(INTERVAL_W'($urandom_range(1, 6)));
        base = items_sent;
        random_transfers(base + RANDOM_ITEMS / 6);

        // Closing stretch at full rate on both sides.
        write_interval(8'd1);
        tx_gaps = 0;
        rx_gaps = 0;
        base = items_sent;
        random_transfers(base + RANDOM_ITEMS / 8);

        drain();
        repeat (8) @(negedge i_clk);
        if (tracker.pending.size() != 0) begin
            $error("%0d result words never arrived", tracker.pending.size());
            tracker.mismatches++;
        end
        $display("Sent %0d command words and checked %0d result words.",
                 items_sent, tracker.words_checked);
        $display("Covered %0d packets, %0d zero-length packets and %0d puts refused on a full ring.",
                 tracker.packets, tracker.zlps, tracker.rejected);
        if (tracker.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
